// ===== rtl/esc_pkg.sv =====
// Shared types and constants for the SCAN elevator controller.
// No dependencies; imported by elevator_scan_controller.
package esc_pkg;

    // Number of floors the design can serve at most (request maps are 32 bits)
    localparam int MAX_FLOORS = 32;
    localparam int FLOOR_CAP  = (MAX_FLOORS < 32) ? MAX_FLOORS : 32;

    localparam int FLOOR_W = 5;
    localparam int MAP_W   = 32;
    localparam int CNT_W   = 6;

    // Input item kinds carried on tuser
    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    // Car direction codes
    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // Register byte offsets
    localparam logic [2:0] REG_FLOORS_IN_USE = 3'd0;
    localparam logic [5:0] FLOORS_RESET      = 6'd32;

endpackage

// ===== rtl/elevator_scan_controller.sv =====
// Single-car SCAN elevator controller: input register, one compute step, result register.
// Depends on esc_pkg for direction and op codes and fixed widths.
//
// Channel   Role      Payload
// s_*       in item   tuser = op; tdata[4:0] board floor, [9:5] exit floor
// m_*       out item  floor_now, direction, stopped_here, up/down maps, rejected
// APB       config    floors_in_use at byte offset 0
//
// One item per cycle unless m_tready stalls; items pass the input and result registers.
// The car state is updated as an item moves from the input register to the result
// register, so consecutive items see each other's effects in order.
// Reset clears the car to floor zero, idle, with empty maps; floors_in_use to 32.
// A stalled result holds the pipeline; the input register still takes one item.
module elevator_scan_controller
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [4:0] board floor, [9:5] exit floor, rest zero
    input  logic        s_tuser,   // [0] op
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [4:0] floor_now, [6:5] direction, [7] stopped_here,
                                   // [39:8] up_pending, [71:40] down_pending,
                                   // [72] rejected, rest zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration register
    logic [CNT_W-1:0] floors_reg;

    // input stage
    logic               in_valid_reg;
    op_t                in_op_reg;
    logic [FLOOR_W-1:0] in_pick_reg;
    logic [FLOOR_W-1:0] in_goal_reg;

    // car state
    logic [FLOOR_W-1:0] floor_reg, floor_next;
    dir_t               dir_reg, dir_next;
    logic [MAP_W-1:0]   up_reg, up_next;
    logic [MAP_W-1:0]   down_reg, down_next;

    // result stage
    logic        out_valid_reg;
    logic [79:0] out_data_reg;
    logic        stopped_next;
    logic        rej_next;

    logic advance;
    logic in_take;

    // pipeline handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // APB port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FLOORS_IN_USE[2]) ? {26'd0, floors_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floors_reg <= FLOORS_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_FLOORS_IN_USE[2]))
        begin
            floors_reg <= pwdata[CNT_W-1:0];
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= op_t'(s_tuser);
            in_pick_reg <= s_tdata[4:0];
            in_goal_reg <= s_tdata[9:5];
        end
    end

    // one step of the controller
    always_comb
    begin
        logic [CNT_W-1:0]   n_eff;
        logic [CNT_W-1:0]   top;
        logic [MAP_W-1:0]   pair;
        logic [MAP_W-1:0]   here;
        logic [MAP_W-1:0]   up_t;
        logic [MAP_W-1:0]   down_t;
        logic [CNT_W-1:0]   floor_x;
        logic               hit_up;
        logic               hit_down;
        logic               any_left;

        // served floor count clamped to 2..FLOOR_CAP
        if (floors_reg < 6'd2)
            n_eff = 6'd2;
        else if (floors_reg > CNT_W'(FLOOR_CAP))
            n_eff = CNT_W'(FLOOR_CAP);
        else
            n_eff = floors_reg;
        top = n_eff - 6'd1;

        pair     = (MAP_W'(1) << in_pick_reg) | (MAP_W'(1) << in_goal_reg);
        here     = MAP_W'(1) << floor_reg;
        floor_x  = {1'b0, floor_reg};
        hit_up   = |(up_reg & here);
        hit_down = |(down_reg & here);
        up_t     = up_reg & ~here;
        down_t   = down_reg & ~here;
        any_left = 1'b0;

        floor_next   = floor_reg;
        dir_next     = dir_reg;
        up_next      = up_reg;
        down_next    = down_reg;
        stopped_next = 1'b0;
        rej_next     = 1'b0;

        if (in_op_reg == OP_REQUEST)
        begin
            if (({1'b0, in_pick_reg} >= n_eff) || ({1'b0, in_goal_reg} >= n_eff))
            begin
                rej_next = 1'b1;
            end
            else
            begin
                unique case (dir_reg)
                    DIR_IDLE:
                    begin
                        if (in_pick_reg < in_goal_reg)
                        begin
                            dir_next = (floor_reg <= in_pick_reg) ? DIR_UP : DIR_DOWN;
                            up_next  = up_reg | pair;
                        end
                        else if (in_pick_reg > in_goal_reg)
                        begin
                            dir_next  = (floor_reg >= in_pick_reg) ? DIR_DOWN : DIR_UP;
                            down_next = down_reg | pair;
                        end
                    end
                    DIR_UP:   up_next   = up_reg | pair;
                    default:  down_next = down_reg | pair;
                endcase
            end
        end
        else
        begin
            unique case (dir_reg)
                DIR_UP:
                begin
                    if (floor_x < top)
                    begin
                        // serve and keep climbing while any request remains
                        stopped_next = hit_up;
                        up_next      = up_t;
                        any_left     = |(up_t | down_reg);
                        if (any_left)
                            floor_next = floor_reg + 5'd1;
                    end
                    else
                    begin
                        // top border: serve both maps and turn round
                        stopped_next = hit_up || hit_down;
                        up_next      = up_t;
                        down_next    = down_t;
                        dir_next     = DIR_DOWN;
                        any_left     = |(up_t | down_t);
                        if (any_left && (floor_reg != 5'd0))
                            floor_next = floor_reg - 5'd1;
                    end
                end
                DIR_DOWN:
                begin
                    if (floor_reg != 5'd0)
                    begin
                        stopped_next = hit_down;
                        down_next    = down_t;
                        any_left     = |(up_reg | down_t);
                        if (any_left)
                            floor_next = floor_reg - 5'd1;
                    end
                    else
                    begin
                        // bottom border: serve both maps and turn round
                        stopped_next = hit_up || hit_down;
                        up_next      = up_t;
                        down_next    = down_t;
                        dir_next     = DIR_UP;
                        any_left     = |(up_t | down_t);
                        if (any_left && (floor_reg != 5'd31))
                            floor_next = floor_reg + 5'd1;
                    end
                end
                default:
                begin
                    any_left = |(up_reg | down_reg);
                end
            endcase
            if (!any_left)
                dir_next = DIR_IDLE;
        end
    end

    // car state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg     <= '0;
            dir_reg       <= DIR_IDLE;
            up_reg        <= '0;
            down_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                floor_reg <= floor_next;
                dir_reg   <= dir_next;
                up_reg    <= up_next;
                down_reg  <= down_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= {7'd0, rej_next, down_next, up_next, stopped_next,
                             dir_next, floor_next};
        end
    end

endmodule
